FILE: sv/wtpm_pkg.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: shared package
// Widths, register map, configuration bundle and the item that passes from
// the window stage to the meter stage.
// ----------------------------------------------------------------------------
package wtpm_pkg;

  localparam int WINDOW_TAPS = 10;
  localparam int MAX_PERIODS = 64;

  localparam int SAMPLE_W = 10;
  localparam int STAMP_W  = 16;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int TOTAL_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int LEVEL_W  = 10;
  localparam int MINP_W   = 16;
  localparam int NEEDED_W = 7;
  localparam int RMS_W    = 12;

  localparam int POS_W = $clog2(WINDOW_TAPS);
  localparam int SUM_W = $clog2(WINDOW_TAPS * ((1 << SAMPLE_W) - 1) + 1);

  // Division of the window sum by the tap count is a multiplication by a
  // rounded-up reciprocal; four guard bits keep the floor exact for every sum.
  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WINDOW_TAPS - 1) / WINDOW_TAPS;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;

  localparam int REC_W = $clog2(MAX_PERIODS + 1);
  localparam int CNT_W = (REC_W > NEEDED_W) ? REC_W : NEEDED_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_TRIGGER_LEVEL     = 3'd0,
    REG_TRIGGER_HALFWIDTH = 3'd1,
    REG_MIN_PERIOD        = 3'd2,
    REG_PERIODS_NEEDED    = 3'd3,
    REG_RMS_SAMPLES       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  trigger_level;
    logic [LEVEL_W-1:0]  trigger_halfwidth;
    logic [MINP_W-1:0]   min_period;
    logic [NEEDED_W-1:0] periods_needed;
    logic [RMS_W-1:0]    rms_samples;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    square;
    logic [STAMP_W-1:0] stamp;
  } win_item_t;

endpackage

FILE: sv/window_trigger_period_meter.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: top level
// Moving-average level trigger that measures and totals signal periods and
// sums the squares of the first samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while neither side stalls and
// returns exactly one result per sample. The rate is set by the window RAM,
// which is read when a sample is taken and written when it moves on, and by
// the running window sum, which is updated once per sample. The ten-entry
// window RAM starts as all zero through per-entry valid bits, so no
// clearing pass follows reset. Both sides may stall freely; configuration
// writes are meant for idle periods.
module window_trigger_period_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wtpm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [wtpm_pkg::STAMP_W-1:0]  in_stamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wtpm_pkg::SAMPLE_W-1:0] out_level_average,
  output logic                          out_period_valid,
  output logic [wtpm_pkg::STAMP_W-1:0]  out_period_ticks,
  output logic [wtpm_pkg::SLOT_W-1:0]   out_period_slot,
  output logic [wtpm_pkg::TOTAL_W-1:0]  out_period_total,
  output logic                          out_periods_done,
  output logic [wtpm_pkg::TOTAL_W-1:0]  out_square_total,
  output logic                          out_square_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [wtpm_pkg::DATA_W-1:0]   pwdata,
  output logic [wtpm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import wtpm_pkg::*;

  cfg_t      cfg;
  logic      b_valid;
  logic      b_ready;
  win_item_t b_item;

  wtpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtpm_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_stamp  (in_stamp),
    .b_valid   (b_valid),
    .b_ready   (b_ready),
    .b_item    (b_item)
  );

  wtpm_meter u_meter (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .b_valid           (b_valid),
    .b_ready           (b_ready),
    .b_item            (b_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level_average (out_level_average),
    .out_period_valid  (out_period_valid),
    .out_period_ticks  (out_period_ticks),
    .out_period_slot   (out_period_slot),
    .out_period_total  (out_period_total),
    .out_periods_done  (out_periods_done),
    .out_square_total  (out_square_total),
    .out_square_done   (out_square_done)
  );

endmodule

FILE: sv/wtpm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module wtpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/wtpm_cfg.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: configuration registers
// APB-style register file holding the trigger window, period limits and
// the sum-of-squares sample count.
// ----------------------------------------------------------------------------
module wtpm_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [wtpm_pkg::ADDR_W-1:0] paddr,
  input  logic [wtpm_pkg::DATA_W-1:0] pwdata,
  output logic [wtpm_pkg::DATA_W-1:0] prdata,
  output logic                  pready,
  output wtpm_pkg::cfg_t        cfg
);
  import wtpm_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_level     <= LEVEL_W'(512);
      cfg_r.trigger_halfwidth <= LEVEL_W'(16);
      cfg_r.min_period        <= MINP_W'(200);
      cfg_r.periods_needed    <= NEEDED_W'(16);
      cfg_r.rms_samples       <= RMS_W'(1000);
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIGGER_LEVEL:     cfg_r.trigger_level     <= pwdata[LEVEL_W-1:0];
        REG_TRIGGER_HALFWIDTH: cfg_r.trigger_halfwidth <= pwdata[LEVEL_W-1:0];
        REG_MIN_PERIOD:        cfg_r.min_period        <= pwdata[MINP_W-1:0];
        REG_PERIODS_NEEDED:    cfg_r.periods_needed    <= pwdata[NEEDED_W-1:0];
        REG_RMS_SAMPLES:       cfg_r.rms_samples       <= pwdata[RMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIGGER_LEVEL:     prdata = DATA_W'(cfg_r.trigger_level);
      REG_TRIGGER_HALFWIDTH: prdata = DATA_W'(cfg_r.trigger_halfwidth);
      REG_MIN_PERIOD:        prdata = DATA_W'(cfg_r.min_period);
      REG_PERIODS_NEEDED:    prdata = DATA_W'(cfg_r.periods_needed);
      REG_RMS_SAMPLES:       prdata = DATA_W'(cfg_r.rms_samples);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

FILE: sv/wtpm_window.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: sample window stage
// Keeps the circular sample window in RAM and a running window sum. The
// old entry is read when a sample is taken and replaced when the sample
// moves on, while the sum is updated and the sample is squared.
// ----------------------------------------------------------------------------
module wtpm_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wtpm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [wtpm_pkg::STAMP_W-1:0]  in_stamp,
  output logic                          b_valid,
  input  logic                          b_ready,
  output wtpm_pkg::win_item_t           b_item
);
  import wtpm_pkg::*;

  // Read stage: the RAM output register belongs to this stage.
  logic                   a_valid_r;
  logic [SAMPLE_W-1:0]    a_sample_r;
  logic [STAMP_W-1:0]     a_stamp_r;
  logic [POS_W-1:0]       a_pos_r;
  logic                   a_old_ok_r;

  logic [POS_W-1:0]       pos_r;
  logic [WINDOW_TAPS-1:0] vld_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SAMPLE_W-1:0]    ram_rdata;
  logic [SAMPLE_W-1:0]    old_sample;

  logic                   b_valid_r;
  win_item_t              b_item_r;

  logic                   accept;
  logic                   a_adv;

  assign a_adv    = a_valid_r && (!b_valid_r || b_ready);
  assign in_ready = !a_valid_r || a_adv;
  assign accept   = in_valid && in_ready;

  // Consecutive samples use consecutive entries, and the sample ten places
  // later, the next to use this entry, is read only after this one is
  // written, so a read never meets a pending write to the same entry.
  wtpm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_TAPS)
  ) u_ram (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_pos_r),
    .wdata (a_sample_r),
    .re    (accept),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Entries never written since reset count as zero.
  assign old_sample = a_old_ok_r ? ram_rdata : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(a_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pos_r     <= '0;
      vld_r     <= '0;
      sum_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
        pos_r     <= (pos_r == POS_W'(WINDOW_TAPS - 1)) ? '0 : pos_r + 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        vld_r[a_pos_r] <= 1'b1;
        sum_r          <= sum_nxt;
        b_valid_r      <= 1'b1;
      end else if (b_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample_r <= in_sample;
      a_stamp_r  <= in_stamp;
      a_pos_r    <= pos_r;
      a_old_ok_r <= vld_r[pos_r];
    end
    if (a_adv) begin
      b_item_r.sum    <= sum_nxt;
      b_item_r.square <= SQ_W'(a_sample_r) * SQ_W'(a_sample_r);
      b_item_r.stamp  <= a_stamp_r;
    end
  end

  assign b_valid = b_valid_r;
  assign b_item  = b_item_r;

endmodule

FILE: sv/wtpm_meter.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: trigger and accumulator stage
// Turns the window sum into the level average, runs the arm and measure
// sequence, keeps the period and square totals and holds the result.
// ----------------------------------------------------------------------------
module wtpm_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtpm_pkg::cfg_t                cfg,
  input  logic                          b_valid,
  output logic                          b_ready,
  input  wtpm_pkg::win_item_t           b_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wtpm_pkg::SAMPLE_W-1:0] out_level_average,
  output logic                          out_period_valid,
  output logic [wtpm_pkg::STAMP_W-1:0]  out_period_ticks,
  output logic [wtpm_pkg::SLOT_W-1:0]   out_period_slot,
  output logic [wtpm_pkg::TOTAL_W-1:0]  out_period_total,
  output logic                          out_periods_done,
  output logic [wtpm_pkg::TOTAL_W-1:0]  out_square_total,
  output logic                          out_square_done
);
  import wtpm_pkg::*;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_out_r;
  logic                pvalid_r;
  logic [STAMP_W-1:0]  ticks_r;
  logic [SLOT_W-1:0]   slot_r;

  logic [SAMPLE_W-1:0] prev_avg_r,  prev_avg_nxt;
  logic                armed_r,     armed_nxt;
  logic [STAMP_W-1:0]  arm_stamp_r, arm_stamp_nxt;
  logic [REC_W-1:0]    recorded_r,  recorded_nxt;
  logic [TOTAL_W-1:0]  period_acc_r, period_acc_nxt;
  logic [TOTAL_W-1:0]  square_acc_r, square_acc_nxt;
  logic [RMS_W-1:0]    square_cnt_r, square_cnt_nxt;
  logic                square_run_r, square_run_nxt;
  logic                halted_r,    halted_nxt;

  logic [SAMPLE_W-1:0] avg_nxt;
  logic                pvalid_nxt;
  logic [STAMP_W-1:0]  ticks_nxt;
  logic [SLOT_W-1:0]   slot_nxt;

  logic [PROD_W-1:0]    prod;
  logic [SAMPLE_W-1:0]  avg;
  logic signed [LEVEL_W+1:0] win_lo;
  logic signed [LEVEL_W+1:0] win_hi;
  logic signed [LEVEL_W+1:0] avg_s;
  logic                 hit;
  logic [STAMP_W-1:0]   period;
  logic                 load;

  assign b_ready = !out_valid_r || out_ready;
  assign load    = b_valid && b_ready;

  assign prod = PROD_W'(b_item.sum) * PROD_W'(DIV_RECIP);
  assign avg  = prod[DIV_SHIFT +: SAMPLE_W];

  // The window bounds are signed, so a lower bound below zero admits zero.
  assign win_lo = $signed({2'b00, cfg.trigger_level}) - $signed({2'b00, cfg.trigger_halfwidth});
  assign win_hi = $signed({2'b00, cfg.trigger_level}) + $signed({2'b00, cfg.trigger_halfwidth});
  assign avg_s  = $signed({2'b00, avg});
  assign hit    = (avg_s > win_lo) && (avg_s < win_hi) && (avg >= prev_avg_r);
  assign period = b_item.stamp - arm_stamp_r;

  always_comb begin
    prev_avg_nxt   = prev_avg_r;
    armed_nxt      = armed_r;
    arm_stamp_nxt  = arm_stamp_r;
    recorded_nxt   = recorded_r;
    period_acc_nxt = period_acc_r;
    square_acc_nxt = square_acc_r;
    square_cnt_nxt = square_cnt_r;
    square_run_nxt = square_run_r;
    halted_nxt     = halted_r;
    avg_nxt        = prev_avg_r;
    pvalid_nxt     = 1'b0;
    ticks_nxt      = '0;
    slot_nxt       = '0;
    if (!halted_r) begin
      avg_nxt      = avg;
      prev_avg_nxt = avg;
      if (hit) begin
        if (armed_r) begin
          if (period > cfg.min_period && recorded_r < REC_W'(MAX_PERIODS)) begin
            period_acc_nxt = period_acc_r + TOTAL_W'(period);
            pvalid_nxt     = 1'b1;
            ticks_nxt      = period;
            slot_nxt       = SLOT_W'(recorded_r);
            recorded_nxt   = recorded_r + 1'b1;
          end
          armed_nxt = 1'b0;
          if (CNT_W'(recorded_nxt) >= CNT_W'(cfg.periods_needed) ||
              recorded_nxt >= REC_W'(MAX_PERIODS)) begin
            halted_nxt = 1'b1;
          end
        end else begin
          arm_stamp_nxt = b_item.stamp;
          armed_nxt     = 1'b1;
        end
      end
      if (square_run_r) begin
        square_acc_nxt = square_acc_r + TOTAL_W'(b_item.square);
        square_cnt_nxt = square_cnt_r + 1'b1;
        // A count of zero after the increment means the counter wrapped.
        if (square_cnt_nxt >= cfg.rms_samples || square_cnt_nxt == '0) begin
          square_run_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_avg_r   <= '0;
      armed_r      <= 1'b0;
      arm_stamp_r  <= '0;
      recorded_r   <= '0;
      period_acc_r <= '0;
      square_acc_r <= '0;
      square_cnt_r <= '0;
      square_run_r <= 1'b1;
      halted_r     <= 1'b0;
    end else if (load) begin
      out_valid_r  <= 1'b1;
      prev_avg_r   <= prev_avg_nxt;
      armed_r      <= armed_nxt;
      arm_stamp_r  <= arm_stamp_nxt;
      recorded_r   <= recorded_nxt;
      period_acc_r <= period_acc_nxt;
      square_acc_r <= square_acc_nxt;
      square_cnt_r <= square_cnt_nxt;
      square_run_r <= square_run_nxt;
      halted_r     <= halted_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avg_out_r <= avg_nxt;
      pvalid_r  <= pvalid_nxt;
      ticks_r   <= ticks_nxt;
      slot_r    <= slot_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_average = avg_out_r;
  assign out_period_valid  = pvalid_r;
  assign out_period_ticks  = ticks_r;
  assign out_period_slot   = slot_r;
  assign out_period_total  = period_acc_r;
  assign out_periods_done  = halted_r;
  assign out_square_total  = square_acc_r;
  assign out_square_done   = !square_run_r;

endmodule

FILE: sv/wtpm_checker.sv
// ----------------------------------------------------------------------------
// Window trigger period meter: port checker
// Watches the result channel for stalled results, idle period fields and
// the sticky completion flags.
// ----------------------------------------------------------------------------
module wtpm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wtpm_pkg::SAMPLE_W-1:0] out_level_average,
  input logic                          out_period_valid,
  input logic [wtpm_pkg::STAMP_W-1:0]  out_period_ticks,
  input logic [wtpm_pkg::SLOT_W-1:0]   out_period_slot,
  input logic                          out_periods_done,
  input logic                          out_square_done
);
  import wtpm_pkg::*;

  logic pdone_seen_r;
  logic sdone_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdone_seen_r <= 1'b0;
      sdone_seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_periods_done) begin
        pdone_seen_r <= 1'b1;
      end
      if (out_square_done) begin
        sdone_seen_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level_average))
    else $error("result changed while stalled");

  a_idle_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_period_valid |-> out_period_ticks == '0 && out_period_slot == '0)
    else $error("period fields set without a recorded period");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pdone_seen_r |-> out_periods_done && !out_period_valid)
    else $error("period recorded after measurement stopped");

  a_square_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sdone_seen_r |-> out_square_done)
    else $error("square summing restarted");

endmodule

bind window_trigger_period_meter wtpm_checker u_wtpm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_level_average (out_level_average),
  .out_period_valid  (out_period_valid),
  .out_period_ticks  (out_period_ticks),
  .out_period_slot   (out_period_slot),
  .out_periods_done  (out_periods_done),
  .out_square_done   (out_square_done)
);
